/* rtl/debounced_tachometer_rpm_defines.svh */
// Assertion macros used by rtl/debounced_tachometer_rpm.sv.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef DEBOUNCED_TACHOMETER_RPM_DEFINES_SVH
`define DEBOUNCED_TACHOMETER_RPM_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset
`define DTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tachometer check failed");

// Check that a condition never holds outside reset
`define DTR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tachometer forbidden condition seen");

`else

`define DTR_ASSERT(lbl, prop)
`define DTR_NEVER(lbl, cond)

`endif

`endif

/* rtl/dtr_pkg.sv */
package dtr_pkg;

  // Field and register widths
  localparam int unsigned DEB_W  = 16;
  localparam int unsigned CHK_W  = 4;
  localparam int unsigned TO_W   = 24;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned RPM_W  = 16;

  // Divider step counter
  localparam int unsigned CNT_W = $clog2(NUM_W);

  // Low-pass accumulator: value shifted up by RPM_W plus a signed product
  localparam int unsigned LP_W = 2 * RPM_W + 3;

  localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]  DEB_RESET  = DEB_W'(100);
  localparam logic [CHK_W-1:0]  CHK_RESET  = CHK_W'(3);
  localparam logic [TO_W-1:0]   TO_RESET   = TO_W'(60000);
  localparam logic [NUM_W-1:0]  NUM_RESET  = NUM_W'(60000000);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6554);

  // Register map, word index
  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_CONFIRM  = 3'd1,
    REG_TIMEOUT  = 3'd2,
    REG_NUMER    = 3'd3,
    REG_GAIN     = 3'd4
  } dtr_reg_e;

  // Item commands
  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_LOWPASS = 1'b1
  } dtr_cmd_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MED,
    ST_DONE
  } dtr_state_e;

endpackage

/* rtl/debounced_tachometer_rpm.sv */
// Flow: a plain tick or a low-pass step goes from input transfer to ST_DONE and output;
// a tick that confirms a pulse runs 32 restoring-divider steps, the median, then output.
// A new item is taken only in ST_IDLE, after the last result is loaded; the single
// one-bit-per-cycle divider makes confirmed pulses the slow path. A result may wait in the output register.
// Reset: rst_ni clears all but payload state, loads register defaults; no clearing pass.
`include "debounced_tachometer_rpm_defines.svh"

module debounced_tachometer_rpm #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] raw_rpm, [31:16] filtered_rpm
  output logic [1:0]  m_axis_tuser,   // [0] new_measurement, [1] timed_out
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RW   = dtr_pkg::RPM_W;
  localparam int unsigned NW   = dtr_pkg::NUM_W;
  localparam int unsigned DivW = ((TIME_WIDTH > NW) ? TIME_WIDTH : NW) + 1;

  // configuration registers
  logic [dtr_pkg::DEB_W-1:0]  cfg_deb_q;
  logic [dtr_pkg::CHK_W-1:0]  cfg_chk_q;
  logic [dtr_pkg::TO_W-1:0]   cfg_to_q;
  logic [NW-1:0]              cfg_num_q;
  logic [dtr_pkg::GAIN_W-1:0] cfg_gain_q;
  logic                       cfg_wr;
  dtr_pkg::dtr_reg_e          cfg_idx;

  // tachometer state
  dtr_pkg::dtr_state_e        state_q, state_d;
  logic [TIME_WIDTH-1:0]      tick_q, tick_d;
  logic [TIME_WIDTH-1:0]      edge_q, edge_d;
  logic [TIME_WIDTH-1:0]      conf_q, conf_d;
  logic [TIME_WIDTH-1:0]      period_q, period_d;
  logic [dtr_pkg::CHK_W-1:0]  chk_q, chk_d;
  logic [dtr_pkg::DEB_W-1:0]  deb_rem_q, deb_rem_d;
  logic                       deb_armed_q, deb_armed_d;
  logic [dtr_pkg::TO_W-1:0]   to_rem_q, to_rem_d;
  logic                       to_armed_q, to_armed_d;
  logic                       prev_pin_q, prev_pin_d;
  logic [RW-1:0]              hist0_q, hist0_d;
  logic [RW-1:0]              hist1_q, hist1_d;
  logic [RW-1:0]              raw_q, raw_d;
  logic [RW-1:0]              smooth_q, smooth_d;
  logic                       fresh_q, fresh_d;
  logic                       expired_q, expired_d;

  // restoring divider
  logic [NW-1:0]              num_q, num_d;
  logic [DivW-1:0]            rem_q, rem_d;
  logic [dtr_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]            div_trial;
  logic                       div_ge;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic                       out_load;
  logic [31:0]                out_data_q;
  logic [1:0]                 out_user_q;

  // helpers
  logic                       in_acc, pin, deb_fire;
  logic [dtr_pkg::DEB_W-1:0]  deb_arm;
  logic [dtr_pkg::TO_W-1:0]   to_arm;
  logic [RW-1:0]              rpm, med_lo, med_hi, med;
  logic signed [RW:0]         lp_diff;
  logic signed [2*RW+1:0]     lp_prod;
  logic signed [dtr_pkg::LP_W-1:0] lp_acc;
  logic [RW-1:0]              lp_res;

  // APB write decode and read mux
  assign pready  = 1'b1;
  assign cfg_idx = dtr_pkg::dtr_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      dtr_pkg::REG_DEBOUNCE: prdata = 32'(cfg_deb_q);
      dtr_pkg::REG_CONFIRM:  prdata = 32'(cfg_chk_q);
      dtr_pkg::REG_TIMEOUT:  prdata = 32'(cfg_to_q);
      dtr_pkg::REG_NUMER:    prdata = cfg_num_q;
      dtr_pkg::REG_GAIN:     prdata = 32'(cfg_gain_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_deb_q  <= dtr_pkg::DEB_RESET;
      cfg_chk_q  <= dtr_pkg::CHK_RESET;
      cfg_to_q   <= dtr_pkg::TO_RESET;
      cfg_num_q  <= dtr_pkg::NUM_RESET;
      cfg_gain_q <= dtr_pkg::GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dtr_pkg::REG_DEBOUNCE: cfg_deb_q  <= pwdata[dtr_pkg::DEB_W-1:0];
        dtr_pkg::REG_CONFIRM:  cfg_chk_q  <= pwdata[dtr_pkg::CHK_W-1:0];
        dtr_pkg::REG_TIMEOUT:  cfg_to_q   <= pwdata[dtr_pkg::TO_W-1:0];
        dtr_pkg::REG_NUMER:    cfg_num_q  <= pwdata;
        dtr_pkg::REG_GAIN:     cfg_gain_q <= pwdata[dtr_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // timer reload values, zero counts as one tick
  assign deb_arm = (cfg_deb_q == '0) ? dtr_pkg::DEB_W'(1) : cfg_deb_q;
  assign to_arm  = (cfg_to_q == '0) ? dtr_pkg::TO_W'(1) : cfg_to_q;

  // low-pass step: s + beta*(r - s), rounded half up
  assign lp_diff = $signed({1'b0, raw_q}) - $signed({1'b0, smooth_q});
  assign lp_prod = lp_diff * $signed({1'b0, cfg_gain_q});
  assign lp_acc  = $signed({3'b000, smooth_q, {RW{1'b0}}})
                 + dtr_pkg::LP_W'(lp_prod)
                 + (dtr_pkg::LP_W'(1) <<< (RW - 1));
  assign lp_res  = lp_acc[2*RW-1:RW];

  // one restoring divider step
  assign div_trial = {rem_q[DivW-2:0], num_q[NW-1]};
  assign div_ge    = (div_trial >= DivW'(period_q));

  // saturate the quotient, take the median of three
  assign rpm    = ((period_q == '0) || (num_q[NW-1:RW] != '0)) ? dtr_pkg::RPM_MAX
                                                               : num_q[RW-1:0];
  assign med_lo = (hist0_q < hist1_q) ? hist0_q : hist1_q;
  assign med_hi = (hist0_q < hist1_q) ? hist1_q : hist0_q;
  assign med    = (rpm <= med_lo) ? med_lo : ((rpm >= med_hi) ? med_hi : rpm);

  assign s_axis_tready = (state_q == dtr_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pin           = s_axis_tdata[0];

  // sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    edge_d      = edge_q;
    conf_d      = conf_q;
    period_d    = period_q;
    chk_d       = chk_q;
    deb_rem_d   = deb_rem_q;
    deb_armed_d = deb_armed_q;
    to_rem_d    = to_rem_q;
    to_armed_d  = to_armed_q;
    prev_pin_d  = prev_pin_q;
    hist0_d     = hist0_q;
    hist1_d     = hist1_q;
    raw_d       = raw_q;
    smooth_d    = smooth_q;
    fresh_d     = fresh_q;
    expired_d   = expired_q;
    num_d       = num_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    deb_fire    = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      dtr_pkg::ST_IDLE: begin
        if (in_acc) begin
          fresh_d   = 1'b0;
          expired_d = 1'b0;
          state_d   = dtr_pkg::ST_DONE;
          if (dtr_pkg::dtr_cmd_e'(s_axis_tuser[0]) == dtr_pkg::CMD_LOWPASS) begin
            smooth_d = lp_res;
          end else begin
            tick_d = tick_q + TIME_WIDTH'(1);
            // timeout runs out first
            if (to_armed_q) begin
              to_rem_d = to_rem_q - dtr_pkg::TO_W'(1);
              if (to_rem_q == dtr_pkg::TO_W'(1)) begin
                to_armed_d = 1'b0;
                raw_d      = '0;
                expired_d  = 1'b1;
              end
            end
            if (deb_armed_q) begin
              deb_rem_d = deb_rem_q - dtr_pkg::DEB_W'(1);
              if (deb_rem_q == dtr_pkg::DEB_W'(1)) begin
                deb_armed_d = 1'b0;
                deb_fire    = 1'b1;
              end
            end
            // re-check the pin at debounce expiry
            if (deb_fire) begin
              if (pin && (chk_q == cfg_chk_q)) begin
                period_d   = edge_q - conf_q;
                conf_d     = edge_q;
                chk_d      = '0;
                to_rem_d   = to_arm;
                to_armed_d = 1'b1;
                fresh_d    = 1'b1;
                num_d      = cfg_num_q;
                rem_d      = '0;
                cnt_d      = '0;
                state_d    = dtr_pkg::ST_DIV;
              end else if (pin) begin
                chk_d       = chk_q + dtr_pkg::CHK_W'(1);
                deb_rem_d   = deb_arm;
                deb_armed_d = 1'b1;
              end else begin
                chk_d = '0;
              end
            end
            // rising edge stamps the time and re-arms debounce
            if (pin && !prev_pin_q) begin
              edge_d      = tick_d;
              chk_d       = '0;
              deb_rem_d   = deb_arm;
              deb_armed_d = 1'b1;
            end
            prev_pin_d = pin;
          end
        end
      end

      dtr_pkg::ST_DIV: begin
        rem_d = div_ge ? (div_trial - DivW'(period_q)) : div_trial;
        num_d = {num_q[NW-2:0], div_ge};
        cnt_d = cnt_q + dtr_pkg::CNT_W'(1);
        if (cnt_q == dtr_pkg::CNT_W'(NW - 1)) begin
          state_d = dtr_pkg::ST_MED;
        end
      end

      dtr_pkg::ST_MED: begin
        raw_d   = med;
        hist1_d = hist0_q;
        hist0_d = rpm;
        state_d = dtr_pkg::ST_DONE;
      end

      dtr_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = dtr_pkg::ST_IDLE;
        end
      end

      default: state_d = dtr_pkg::ST_IDLE;
    endcase
  end

  // output register valid: drop on transfer, set on load
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtr_pkg::ST_IDLE;
      tick_q      <= '0;
      edge_q      <= '0;
      conf_q      <= '0;
      chk_q       <= '0;
      deb_rem_q   <= '0;
      deb_armed_q <= 1'b0;
      to_rem_q    <= '0;
      to_armed_q  <= 1'b0;
      prev_pin_q  <= 1'b0;
      hist0_q     <= '0;
      hist1_q     <= '0;
      raw_q       <= '0;
      smooth_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      edge_q      <= edge_d;
      conf_q      <= conf_d;
      chk_q       <= chk_d;
      deb_rem_q   <= deb_rem_d;
      deb_armed_q <= deb_armed_d;
      to_rem_q    <= to_rem_d;
      to_armed_q  <= to_armed_d;
      prev_pin_q  <= prev_pin_d;
      hist0_q     <= hist0_d;
      hist1_q     <= hist1_d;
      raw_q       <= raw_d;
      smooth_q    <= smooth_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    period_q  <= period_d;
    fresh_q   <= fresh_d;
    expired_q <= expired_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    if (out_load) begin
      out_data_q <= {smooth_q, raw_q};
      out_user_q <= {expired_q, fresh_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // a division only runs after a confirmation, which arms the timeout
  `DTR_ASSERT(a_div_timeout_armed, (state_q == dtr_pkg::ST_DIV) |-> to_armed_q)
  // a low-pass step needs no division
  `DTR_ASSERT(a_lowpass_short, (in_acc && s_axis_tuser[0]) |=> (state_q == dtr_pkg::ST_DONE))
  // the last divider step hands over to the median
  `DTR_ASSERT(a_div_to_med,
    (state_q == dtr_pkg::ST_DIV && cnt_q == dtr_pkg::CNT_W'(NW - 1)) |=>
      (state_q == dtr_pkg::ST_MED))
  // a new result only appears from the finishing state
  `DTR_ASSERT(a_out_from_done, $rose(out_valid_q) |-> ($past(state_q) == dtr_pkg::ST_DONE))

endmodule
